// ===== rtl/core/lprf_pkg.sv =====
// Shared types and constants of the length-prefixed record FIFO.
`default_nettype none

package lprf_pkg;

  localparam int unsigned BUF_BYTES_DEF  = 256;
  localparam int unsigned MAX_RECORD_DEF = 64;
  localparam int unsigned LEN_W          = 7;
  localparam logic [LEN_W-1:0] LIMIT_RESET = 7'd64;

  typedef enum logic [1:0] {
    ACT_BEGIN = 2'd0,
    ACT_DATA  = 2'd1,
    ACT_GET   = 2'd2
  } lprf_action_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_ROOM = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_BAD_LEN = 3'd3,
    ST_SEQ     = 3'd4
  } lprf_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WR_HI,
    S_RD_HI,
    S_CHECK,
    S_STREAM
  } lprf_state_e;

  typedef struct packed {
    logic [1:0]       action;
    logic [LEN_W-1:0] length;
    logic [7:0]       data_byte;
  } lprf_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       last;
  } lprf_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/length_prefixed_record_fifo_core.sv =====
// Length-prefixed record FIFO: top level with ring memory and sequencer.
//
// Input channel (in_valid_i / in_stall_o / in_i) takes begin-add, data-byte
// and get transactions; each record is stored as a two-byte little-endian
// length followed by its bytes. Output channel (out_valid_o / out_stall_i /
// out_o) returns results from a single result register.
// Begin, data-byte and refused items give one result the cycle after
// acceptance. A successful begin makes two prefix writes on the single write
// port, the high byte in S_WR_HI; a data byte makes one write.
// A get reads the low prefix byte at acceptance and the high one the cycle
// after, checks the length in S_CHECK and then streams one record byte per
// cycle while out_stall_i is low; a failed check or a zero-length record
// sets its result in S_CHECK.
// A new transaction is taken only once the previous one has finished and
// the result register is empty or being drained in that cycle.
// out_stall_i holds the result register and pauses the byte stream; the
// ring read data is held, so nothing is lost.
// Reset empties the store and sets max_record_len to 64; no clearing pass.
// cfg_we_i/cfg_wdata_i write max_record_len; write it only while idle.
`default_nettype none

module length_prefixed_record_fifo_core import lprf_pkg::*; #(
  parameter int unsigned BUF_BYTES  = BUF_BYTES_DEF,
  parameter int unsigned MAX_RECORD = MAX_RECORD_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire lprf_in_t         in_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output lprf_out_t             out_o,
  input  wire logic             cfg_we_i,
  input  wire logic [LEN_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW = $clog2(BUF_BYTES);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  lprf_ctrl #(
    .BUF_BYTES (BUF_BYTES),
    .MAX_RECORD(MAX_RECORD),
    .AW        (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  lprf_ram #(
    .DEPTH(BUF_BYTES),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // ring accesses are interlocked: never a read and a write in one cycle
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("ring read and write in the same cycle");

  a_data_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_i.action == ACT_DATA)) |=> out_valid_o)
    else $error("data-byte transaction gave no result");

  a_byte_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.out_valid) |-> (out_o.status == ST_OK))
    else $error("record byte with non-ok status");

  a_read_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> in_stall_o || !in_valid_i || (in_i.action == ACT_GET))
    else $error("input taken while ring read in progress");

endmodule

`default_nettype wire

// ===== rtl/core/lprf_ram.sv =====
// Byte ring memory: one write port, one read port with registered read data.
`default_nettype none

module lprf_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/lprf_ctrl.sv =====
// Sequencer: ring pointers, add/get control, limit register and result register.
`default_nettype none

module lprf_ctrl import lprf_pkg::*; #(
  parameter int unsigned BUF_BYTES  = BUF_BYTES_DEF,
  parameter int unsigned MAX_RECORD = MAX_RECORD_DEF,
  parameter int unsigned AW         = $clog2(BUF_BYTES)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire lprf_in_t         in_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output lprf_out_t             out_o,
  input  wire logic             cfg_we_i,
  input  wire logic [LEN_W-1:0] cfg_wdata_i,
  output logic                  mem_we_o,
  output logic [AW-1:0]         mem_waddr_o,
  output logic [7:0]            mem_wdata_o,
  output logic                  mem_re_o,
  output logic [AW-1:0]         mem_raddr_o,
  input  wire logic [7:0]       mem_rdata_i
);

  localparam int unsigned UW = $clog2(BUF_BYTES + 1);
  localparam int unsigned SW = ((UW > LEN_W) ? UW : LEN_W) + 1;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
    if (p == AW'(BUF_BYTES - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  lprf_state_e      state_q, state_d;
  logic [AW-1:0]    wr_head_q, wr_head_d;
  logic [UW-1:0]    used_q, used_d;
  logic [AW-1:0]    pend_head_q, pend_head_d;
  logic [LEN_W-1:0] pend_cnt_q, pend_cnt_d;
  logic [LEN_W-1:0] pend_len_q, pend_len_d;
  logic             add_pend_q, add_pend_d;
  logic [LEN_W-1:0] limit_cfg_q, limit_cfg_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [LEN_W-1:0] remain_q, remain_d;
  logic [7:0]       len_lo_q, len_lo_d;
  logic             out_vld_q, out_vld_d;
  lprf_status_e     out_status_q, out_status_d;
  logic             out_last_q, out_last_d;
  logic             out_bmode_q, out_bmode_d;

  logic [LEN_W-1:0] limit;
  logic [SW-1:0]    room_sum;
  logic             no_room;
  logic [SW-1:0]    tail_sum;
  logic [AW-1:0]    tail;
  logic [SW-1:0]    used_m2;
  logic             out_free;
  logic             accept;

  assign limit    = (limit_cfg_q < LEN_W'(MAX_RECORD)) ? limit_cfg_q : LEN_W'(MAX_RECORD);
  assign room_sum = SW'(used_q) + SW'(in_i.length) + SW'(2);
  assign no_room  = room_sum > SW'(BUF_BYTES);
  // oldest record starts used_q bytes behind the committed write head
  assign tail_sum = SW'(wr_head_q) + SW'(BUF_BYTES) - SW'(used_q);
  assign tail     = (tail_sum >= SW'(BUF_BYTES)) ? AW'(tail_sum - SW'(BUF_BYTES))
                                                  : AW'(tail_sum);
  assign used_m2  = SW'(used_q) - SW'(2);

  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d      = state_q;
    wr_head_d    = wr_head_q;
    used_d       = used_q;
    pend_head_d  = pend_head_q;
    pend_cnt_d   = pend_cnt_q;
    pend_len_d   = pend_len_q;
    add_pend_d   = add_pend_q;
    limit_cfg_d  = cfg_we_i ? cfg_wdata_i : limit_cfg_q;
    rd_ptr_d     = rd_ptr_q;
    remain_d     = remain_q;
    len_lo_d     = len_lo_q;
    out_vld_d    = out_vld_q && out_stall_i;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    out_bmode_d  = out_bmode_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = wr_head_q;
    mem_wdata_o  = '0;
    mem_re_o     = 1'b0;
    mem_raddr_o  = rd_ptr_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          // default: one status-only result
          out_vld_d    = 1'b1;
          out_last_d   = 1'b1;
          out_bmode_d  = 1'b0;
          out_status_d = ST_SEQ;
          unique case (in_i.action)
            ACT_BEGIN: begin
              if (add_pend_q) begin
                out_status_d = ST_SEQ;
              end else if ((in_i.length > limit) || no_room) begin
                out_status_d = ST_NO_ROOM;
              end else begin
                out_status_d = ST_OK;
                mem_we_o     = 1'b1;
                mem_waddr_o  = wr_head_q;
                mem_wdata_o  = {1'b0, in_i.length};
                pend_head_d  = adv(wr_head_q);
                pend_len_d   = in_i.length;
                pend_cnt_d   = in_i.length;
                add_pend_d   = (in_i.length != '0);
                state_d      = S_WR_HI;
              end
            end
            ACT_DATA: begin
              if (!add_pend_q) begin
                out_status_d = ST_SEQ;
              end else begin
                out_status_d = ST_OK;
                mem_we_o     = 1'b1;
                mem_waddr_o  = pend_head_q;
                mem_wdata_o  = in_i.data_byte;
                pend_head_d  = adv(pend_head_q);
                pend_cnt_d   = pend_cnt_q - 1'b1;
                if (pend_cnt_q == LEN_W'(1)) begin
                  add_pend_d = 1'b0;
                  used_d     = UW'(SW'(used_q) + SW'(pend_len_q) + SW'(2));
                  wr_head_d  = adv(pend_head_q);
                end
              end
            end
            ACT_GET: begin
              if (add_pend_q) begin
                out_status_d = ST_SEQ;
              end else if (used_q <= UW'(2)) begin
                out_status_d = ST_EMPTY;
              end else begin
                out_vld_d   = 1'b0;
                mem_re_o    = 1'b1;
                mem_raddr_o = tail;
                rd_ptr_d    = adv(tail);
                state_d     = S_RD_HI;
              end
            end
            default: begin
              out_status_d = ST_SEQ;
            end
          endcase
        end
      end
      S_WR_HI: begin
        // high prefix byte is always zero
        mem_we_o    = 1'b1;
        mem_waddr_o = pend_head_q;
        mem_wdata_o = '0;
        pend_head_d = adv(pend_head_q);
        if (pend_len_q == '0) begin
          used_d    = UW'(SW'(used_q) + SW'(2));
          wr_head_d = adv(pend_head_q);
        end
        state_d = S_IDLE;
      end
      S_RD_HI: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = rd_ptr_q;
        rd_ptr_d    = adv(rd_ptr_q);
        len_lo_d    = mem_rdata_i;
        state_d     = S_CHECK;
      end
      S_CHECK: begin
        out_last_d  = 1'b1;
        out_bmode_d = 1'b0;
        if ((mem_rdata_i != '0) || (SW'(len_lo_q) > used_m2) ||
            (len_lo_q > 8'(limit))) begin
          out_vld_d    = 1'b1;
          out_status_d = ST_BAD_LEN;
          state_d      = S_IDLE;
        end else begin
          used_d = UW'(SW'(used_q) - SW'(len_lo_q) - SW'(2));
          if (len_lo_q == '0) begin
            out_vld_d    = 1'b1;
            out_status_d = ST_OK;
            state_d      = S_IDLE;
          end else begin
            remain_d = LEN_W'(len_lo_q);
            state_d  = S_STREAM;
          end
        end
      end
      S_STREAM: begin
        // issue the next read only when the result register frees up
        if (out_free) begin
          mem_re_o     = 1'b1;
          mem_raddr_o  = rd_ptr_q;
          rd_ptr_d     = adv(rd_ptr_q);
          remain_d     = remain_q - 1'b1;
          out_vld_d    = 1'b1;
          out_status_d = ST_OK;
          out_bmode_d  = 1'b1;
          out_last_d   = (remain_q == LEN_W'(1));
          if (remain_q == LEN_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wr_head_q   <= '0;
      used_q      <= '0;
      pend_head_q <= '0;
      pend_cnt_q  <= '0;
      pend_len_q  <= '0;
      add_pend_q  <= 1'b0;
      limit_cfg_q <= LIMIT_RESET;
      rd_ptr_q    <= '0;
      remain_q    <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_head_q   <= wr_head_d;
      used_q      <= used_d;
      pend_head_q <= pend_head_d;
      pend_cnt_q  <= pend_cnt_d;
      pend_len_q  <= pend_len_d;
      add_pend_q  <= add_pend_d;
      limit_cfg_q <= limit_cfg_d;
      rd_ptr_q    <= rd_ptr_d;
      remain_q    <= remain_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_lo_q     <= len_lo_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
    out_bmode_q  <= out_bmode_d;
  end

  assign out_valid_o     = out_vld_q;
  assign out_o.status    = out_status_q;
  assign out_o.out_valid = out_bmode_q;
  assign out_o.out_byte  = out_bmode_q ? mem_rdata_i : 8'd0;
  assign out_o.last      = out_last_q;

endmodule

`default_nettype wire
